// ===== rtl/core/dtl_pkg.sv =====
// Package for the delimited token lexer: sizes, codes, fixed byte values
// and the structs shared by the step logic and the top level.
// No dependencies.
package dtl_pkg;

  // Largest document offset tracked; the offset counter saturates here.
  localparam int unsigned MAX_DOC_BYTES = 65536;
  localparam int unsigned OFS_W         = $clog2(MAX_DOC_BYTES + 1);

  // Fixed widths of the payload fields.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CIDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_COMMENT = 3'd0;
  localparam logic [CIDX_W-1:0] REG_NUMBER  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_STRING  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ESCAPE  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_NULL    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] RST_COMMENT = 8'd35;
  localparam logic [BYTE_W-1:0] RST_NUMBER  = 8'd39;
  localparam logic [BYTE_W-1:0] RST_STRING  = 8'd34;
  localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'd92;
  localparam logic [BYTE_W-1:0] RST_NULL    = 8'd95;

  // Fixed single-byte token characters.
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LPAREN   = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN   = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_NULL     = 4'd0,
    KIND_LBRACKET = 4'd1,
    KIND_RBRACKET = 4'd2,
    KIND_LBRACE   = 4'd3,
    KIND_RBRACE   = 4'd4,
    KIND_LPAREN   = 4'd5,
    KIND_RPAREN   = 4'd6,
    KIND_WS       = 4'd7,
    KIND_COMMENT  = 4'd8,
    KIND_NUMBER   = 4'd9,
    KIND_STRING   = 4'd10,
    KIND_UNKNOWN  = 4'd11
  } token_kind_e;

  typedef enum logic [1:0] {
    Q_COMMENT = 2'd0,
    Q_NUMBER  = 2'd1,
    Q_STRING  = 2'd2
  } quote_e;

  typedef struct packed {
    logic [BYTE_W-1:0] comment_char;
    logic [BYTE_W-1:0] number_char;
    logic [BYTE_W-1:0] string_char;
    logic [BYTE_W-1:0] escape_char;
    logic [BYTE_W-1:0] null_char;
  } cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0] byte_offset;
    logic [OFS_W-1:0] start_offset;
    logic             in_quoted;
    quote_e           quote_kind;
    logic             escape_pending;
  } lex_state_t;

  typedef struct packed {
    token_kind_e        kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               final_tok;
  } token_t;

endpackage

// ===== rtl/core/dtl_step.sv =====
// Per-byte lexer step: from the current state, the registers and one byte,
// forms the next state and at most one token. Uses dtl_pkg.
module dtl_step (
  input  dtl_pkg::cfg_t              cfg_i,
  input  dtl_pkg::lex_state_t        state_i,
  input  logic [dtl_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       eod_i,
  output dtl_pkg::lex_state_t        state_o,
  output logic                       emit_o,
  output dtl_pkg::token_t            token_o
);

  localparam logic [dtl_pkg::OFS_W-1:0] OFS_MAX  = dtl_pkg::OFS_W'(dtl_pkg::MAX_DOC_BYTES);
  localparam logic [dtl_pkg::OFS_W-1:0] OFS_LAST =
    dtl_pkg::OFS_W'(dtl_pkg::MAX_DOC_BYTES - 1);

  function automatic dtl_pkg::token_kind_e single_kind(
    input logic [dtl_pkg::BYTE_W-1:0] b,
    input logic [dtl_pkg::BYTE_W-1:0] null_char
  );
    dtl_pkg::token_kind_e k;
    if (b == null_char) begin
      k = dtl_pkg::KIND_NULL;
    end else begin
      case (b)
        dtl_pkg::CH_LBRACKET: k = dtl_pkg::KIND_LBRACKET;
        dtl_pkg::CH_RBRACKET: k = dtl_pkg::KIND_RBRACKET;
        dtl_pkg::CH_LBRACE:   k = dtl_pkg::KIND_LBRACE;
        dtl_pkg::CH_RBRACE:   k = dtl_pkg::KIND_RBRACE;
        dtl_pkg::CH_LPAREN:   k = dtl_pkg::KIND_LPAREN;
        dtl_pkg::CH_RPAREN:   k = dtl_pkg::KIND_RPAREN;
        dtl_pkg::CH_SPACE, dtl_pkg::CH_TAB,
        dtl_pkg::CH_LF, dtl_pkg::CH_CR: k = dtl_pkg::KIND_WS;
        default:              k = dtl_pkg::KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  logic [dtl_pkg::OFS_W-1:0] here;
  logic [dtl_pkg::OFS_W-1:0] tok_end;
  logic [dtl_pkg::OFS_W-1:0] tok_start;
  logic [dtl_pkg::BYTE_W-1:0] qual;
  logic                      is_qual;
  dtl_pkg::quote_e           open_kind;
  dtl_pkg::token_kind_e      kind;
  dtl_pkg::token_kind_e      quoted_kind;

  always_comb begin
    here    = (state_i.byte_offset < OFS_LAST) ? state_i.byte_offset : OFS_LAST;
    tok_end = (state_i.byte_offset < OFS_MAX) ? state_i.byte_offset + 1'b1 : OFS_MAX;

    case (state_i.quote_kind)
      dtl_pkg::Q_COMMENT: begin
        qual        = cfg_i.comment_char;
        quoted_kind = dtl_pkg::KIND_COMMENT;
      end
      dtl_pkg::Q_NUMBER: begin
        qual        = cfg_i.number_char;
        quoted_kind = dtl_pkg::KIND_NUMBER;
      end
      default: begin
        qual        = cfg_i.string_char;
        quoted_kind = dtl_pkg::KIND_STRING;
      end
    endcase

    // Opening qualifier, with comment before number before string.
    is_qual   = 1'b1;
    open_kind = dtl_pkg::Q_COMMENT;
    if (data_byte_i == cfg_i.comment_char) begin
      open_kind = dtl_pkg::Q_COMMENT;
    end else if (data_byte_i == cfg_i.number_char) begin
      open_kind = dtl_pkg::Q_NUMBER;
    end else if (data_byte_i == cfg_i.string_char) begin
      open_kind = dtl_pkg::Q_STRING;
    end else begin
      is_qual = 1'b0;
    end

    state_o             = state_i;
    state_o.byte_offset = (state_i.byte_offset < OFS_MAX) ?
                          state_i.byte_offset + 1'b1 : state_i.byte_offset;
    emit_o    = 1'b0;
    kind      = dtl_pkg::KIND_UNKNOWN;
    tok_start = here;

    if (state_i.in_quoted) begin
      tok_start = state_i.start_offset;
      if (data_byte_i == qual) begin
        if (state_i.escape_pending) begin
          state_o.escape_pending = 1'b0;
          if (eod_i) begin
            emit_o = 1'b1;
          end
        end else begin
          // Unescaped closing qualifier ends the token.
          emit_o                 = 1'b1;
          kind                   = quoted_kind;
          state_o.in_quoted      = 1'b0;
          state_o.escape_pending = 1'b0;
        end
      end else begin
        if (data_byte_i == cfg_i.escape_char) begin
          state_o.escape_pending = !state_i.escape_pending;
        end else begin
          state_o.escape_pending = 1'b0;
        end
        if (eod_i) begin
          emit_o = 1'b1;
        end
      end
    end else if (is_qual) begin
      if (eod_i) begin
        emit_o = 1'b1;
      end else begin
        state_o.in_quoted      = 1'b1;
        state_o.quote_kind     = open_kind;
        state_o.escape_pending = 1'b0;
        state_o.start_offset   = here;
      end
    end else begin
      emit_o = 1'b1;
      kind   = single_kind(data_byte_i, cfg_i.null_char);
    end

    // Document end: drop all state so the next byte starts at offset 0.
    if (eod_i) begin
      state_o = '0;
    end

    token_o.kind      = kind;
    token_o.start     = dtl_pkg::START_W'(tok_start);
    token_o.length    = dtl_pkg::LEN_W'(tok_end - tok_start);
    token_o.final_tok = eod_i;
  end

endmodule

// ===== rtl/core/delimited_token_lexer.sv =====
// Top level of the delimited token lexer: input register, per-byte step
// logic (dtl_step) and the token result register. Uses dtl_pkg.
//
//   channel   direction  handshake               payload
//   in        request    in_valid_i/in_ready_o   data_byte_i, end_of_document_i
//   out       result     out_valid_o/out_ready_i token_kind_o, token_start_o,
//                                                token_length_o, final_token_o
//   cfg       write      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One byte per cycle sustained. A request lands in the input register, is
// lexed by the step logic against the lexer state, and its token (if any)
// lands in the result register. Reset restores the configuration registers
// to their defaults and clears the lexer state. A stalled result only blocks
// a byte that would produce a token; bytes inside a quoted token keep flowing.
module delimited_token_lexer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtl_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        end_of_document_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dtl_pkg::KIND_W-1:0]  token_kind_o,
  output logic [dtl_pkg::START_W-1:0] token_start_o,
  output logic [dtl_pkg::LEN_W-1:0]   token_length_o,
  output logic                        final_token_o,
  input  logic                        cfg_we_i,
  input  logic [dtl_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [dtl_pkg::BYTE_W-1:0]  cfg_wdata_i
);

  // Configuration registers.
  dtl_pkg::cfg_t cfg_q, cfg_d;

  // Input register holding one request.
  logic                       in_valid_q;
  logic [dtl_pkg::BYTE_W-1:0] in_byte_q;
  logic                       in_eod_q;

  // Lexer state and result register.
  dtl_pkg::lex_state_t state_q, state_d;
  logic                out_valid_q;
  dtl_pkg::token_t     out_tok_q;

  logic            step_emit;
  dtl_pkg::token_t step_tok;
  logic            in_fire;
  logic            step_go;
  logic            out_free;

  dtl_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .eod_i       (in_eod_q),
    .state_o     (state_d),
    .emit_o      (step_emit),
    .token_o     (step_tok)
  );

  // The held byte advances when the result register can take its token,
  // or at once when it produces none.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_go    = in_valid_q && (out_free || !step_emit);
  assign in_ready_o = !in_valid_q || step_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // Register write decode; indexes past the last register are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtl_pkg::REG_COMMENT: cfg_d.comment_char = cfg_wdata_i;
        dtl_pkg::REG_NUMBER:  cfg_d.number_char  = cfg_wdata_i;
        dtl_pkg::REG_STRING:  cfg_d.string_char  = cfg_wdata_i;
        dtl_pkg::REG_ESCAPE:  cfg_d.escape_char  = cfg_wdata_i;
        dtl_pkg::REG_NULL:    cfg_d.null_char    = cfg_wdata_i;
        default:              cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comment_char <= dtl_pkg::RST_COMMENT;
      cfg_q.number_char  <= dtl_pkg::RST_NUMBER;
      cfg_q.string_char  <= dtl_pkg::RST_STRING;
      cfg_q.escape_char  <= dtl_pkg::RST_ESCAPE;
      cfg_q.null_char    <= dtl_pkg::RST_NULL;
      in_valid_q         <= 1'b0;
      state_q            <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      // Hold the request until the step logic consumes it.
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step_go) begin
        in_valid_q <= 1'b0;
      end
      if (step_go) begin
        state_q <= state_d;
      end
      // Load a new token or drop the delivered one.
      if (step_go && step_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= data_byte_i;
      in_eod_q  <= end_of_document_i;
    end
    if (step_go && step_emit) begin
      out_tok_q <= step_tok;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = dtl_pkg::KIND_W'(out_tok_q.kind);
  assign token_start_o  = out_tok_q.start;
  assign token_length_o = out_tok_q.length;
  assign final_token_o  = out_tok_q.final_tok;

endmodule

// ===== rtl/core/dtl_checker.sv =====
// Port-level checks for the delimited token lexer, bound to the top level.
// Uses dtl_pkg.
module dtl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [dtl_pkg::KIND_W-1:0]  token_kind_o,
  input logic [dtl_pkg::START_W-1:0] token_start_o,
  input logic [dtl_pkg::LEN_W-1:0]   token_length_o,
  input logic                        final_token_o
);

  // A stalled token holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_start_o) && $stable(token_length_o) && $stable(final_token_o))
    else $error("stalled token changed");

  // No token kind beyond unknown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= dtl_pkg::KIND_W'(dtl_pkg::KIND_UNKNOWN))
    else $error("token kind out of range");

  // Every token covers at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_length_o != '0)
    else $error("empty token");

  // Null, bracket, brace, parenthesis and whitespace tokens are exactly one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o <= dtl_pkg::KIND_W'(dtl_pkg::KIND_WS)
      |-> token_length_o == dtl_pkg::LEN_W'(1))
    else $error("single-byte token with wrong length");

endmodule

bind delimited_token_lexer dtl_checker u_dtl_checker (.*);
